FILE: hdl/sumd_pkg.sv
// Shared types, protocol constants and the CRC step for the SUMD frame decoder.
// Used by sumd_front, sumd_engine and sumd_frame_decoder; depends on nothing.
package sumd_pkg;

    // Frame header bytes and limits.
    localparam logic [7:0]  HDR_START    = 8'hA8;
    localparam logic [7:0]  HDR_OK       = 8'h01;
    localparam logic [7:0]  HDR_FAILSAFE = 8'h81;
    localparam logic [7:0]  MIN_CHANNELS = 8'h02;
    localparam logic [6:0]  HDR_LEN      = 7'd3;
    localparam logic [6:0]  CRC_LEN      = 7'd2;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_MSB      = 16'h8000;
    localparam logic [15:0] TIMEOUT_RST  = 16'd100;
    localparam logic [15:0] MS_MAX       = 16'hFFFF;

    // Input item modes and output record kinds.
    localparam logic MODE_BYTE   = 1'b0;
    localparam logic MODE_TICK   = 1'b1;
    localparam logic KIND_CHAN   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One classified input item as it travels through the queue.
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } item_t;

    // One result record.
    typedef struct packed {
        logic        kind;
        logic [4:0]  channel_index;
        logic [12:0] channel_value;
        logic [5:0]  channels_received;
        logic        failsafe_active;
        logic        last;
    } record_t;

    // One byte of CRC16-CCITT, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] v);
        logic [15:0] c;
        c = crc_in ^ {v, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hdl/sumd_frame_decoder.sv
// Top level of the SUMD frame decoder: joins the input front and the engine.
// Depends on sumd_pkg, sumd_front and sumd_engine.
//
// Takes received bytes (mode 0) and millisecond ticks (mode 1). Bytes go into a
// RING_DEPTH-entry ring. Once a header and the whole frame are held, a CRC16
// check runs, and a good frame yields one channel record per channel. A tick
// yields one status record. A sequencer works on one item at a time. It has a
// single registered ring read port, so each ring byte read is an address state
// and then a data state. Each header probe of a candidate start byte is three
// reads and a return to the scan. A CRC check reads every byte of the frame, and
// the channel emission can be held by an output stall. A two-entry input queue
// lets items arrive while the engine is busy. Ring contents are not cleared at
// reset; only written entries are ever read.
module sumd_frame_decoder
#(
    parameter int RING_DEPTH   = 128,
    parameter int MAX_CHANNELS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [4:0]  channel_index,
    output logic [12:0] channel_value,
    output logic [5:0]  channels_received,
    output logic        failsafe_active,
    output logic        last,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic              q_valid;
    logic              q_pop;
    sumd_pkg::item_t   q_item;
    sumd_pkg::record_t rec;

    sumd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .rx_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    sumd_engine
    #(
        .RING_DEPTH   (RING_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rec   (rec)
    );

    // Record fields onto their own ports.
    assign kind              = rec.kind;
    assign channel_index     = rec.channel_index;
    assign channel_value     = rec.channel_value;
    assign channels_received = rec.channels_received;
    assign failsafe_active   = rec.failsafe_active;
    assign last              = rec.last;

endmodule

FILE: hdl/sumd_front.sv
// Front part of the SUMD decoder: accepts input items, classifies them and
// holds them in a two-entry queue for the engine. Depends on sumd_pkg.
module sumd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            mode,
    input  logic [7:0]      rx_byte,
    output logic            q_valid,
    input  logic            q_pop,
    output sumd_pkg::item_t q_item
);

    sumd_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;
    sumd_pkg::item_t item_in;

    // Classify the incoming transfer.
    always_comb
    begin
        item_in.is_tick = (mode == sumd_pkg::MODE_TICK);
        item_in.data    = rx_byte;
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // Queue pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= item_in;
    end

endmodule

FILE: hdl/sumd_engine.sv
// Back part of the SUMD decoder: byte ring, header scan, CRC check, channel
// emission and status records. Depends on sumd_pkg.
module sumd_engine
#(
    parameter int RING_DEPTH   = 128,
    parameter int MAX_CHANNELS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  sumd_pkg::item_t   q_item,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    output logic              out_valid,
    input  logic              out_ready,
    output sumd_pkg::record_t out_rec
);

    localparam int          PW      = $clog2(RING_DEPTH);
    localparam logic [PW:0] DEPTH_W = (PW + 1)'(RING_DEPTH);
    localparam logic [7:0]  MAX_CH  = 8'(MAX_CHANNELS);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SCAN    = 11'b000_0000_0010,
        S_HDR_A   = 11'b000_0000_0100,
        S_HDR_D   = 11'b000_0000_1000,
        S_CRC_A   = 11'b000_0001_0000,
        S_CRC_D   = 11'b000_0010_0000,
        S_CRC_END = 11'b000_0100_0000,
        S_HI_A    = 11'b000_1000_0000,
        S_HI_D    = 11'b001_0000_0000,
        S_LO_A    = 11'b010_0000_0000,
        S_LO_D    = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     rp_reg, rp_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic              hdr_seen_reg, hdr_seen_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              fs_reg, fs_next;
    logic [5:0]        last_cnt_reg, last_cnt_next;
    logic [15:0]       ms_reg, ms_next;
    logic [15:0]       timeout_reg;
    logic [15:0]       crc_reg, crc_next;
    logic [6:0]        k_reg, k_next;
    logic [4:0]        ch_reg, ch_next;
    logic [7:0]        h0_reg, h0_next;
    logic [7:0]        h1_reg, h1_next;
    logic              out_valid_reg, out_valid_next;
    sumd_pkg::record_t out_rec_reg, out_rec_next;

    logic [7:0]        ring [RING_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [6:0]        rd_off;
    logic [PW-1:0]     rd_addr;
    logic              wr_en;

    logic [PW:0]       held;
    logic [6:0]        flen;
    logic              slot_free;
    logic [15:0]       ms_inc;
    logic [PW-1:0]     wp_inc;
    logic              hdr_ok;
    logic [12:0]       ch_value;

    // Ring index plus offset, wrapped once at the depth.
    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base, input logic [6:0] off);
        logic [PW:0] s;
        s = {1'b0, base} + (PW + 1)'(off);
        if (s >= DEPTH_W)
            s = s - DEPTH_W;
        return s[PW-1:0];
    endfunction

    // Derived values shared by several states.
    always_comb
    begin
        if (wp_reg >= rp_reg)
            held = {1'b0, wp_reg} - {1'b0, rp_reg};
        else
            held = {1'b0, wp_reg} + DEPTH_W - {1'b0, rp_reg};
        flen      = {cnt_reg, 1'b0} + sumd_pkg::HDR_LEN + sumd_pkg::CRC_LEN;
        slot_free = !out_valid_reg || out_ready;
        ms_inc    = (ms_reg == sumd_pkg::MS_MAX) ? ms_reg : ms_reg + 16'd1;
        wp_inc    = ring_add(wp_reg, 7'd1);
        hdr_ok    = (h0_reg == sumd_pkg::HDR_START)
                    && (h1_reg == sumd_pkg::HDR_OK || h1_reg == sumd_pkg::HDR_FAILSAFE)
                    && (rd_data_reg >= sumd_pkg::MIN_CHANNELS) && (rd_data_reg <= MAX_CH);
        ch_value  = {h0_reg, 5'b00000} + {8'h00, rd_data_reg[7:3]};
    end

    // Sequencer for one item at a time.
    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        hdr_seen_next  = hdr_seen_reg;
        cnt_next       = cnt_reg;
        fs_next        = fs_reg;
        last_cnt_next  = last_cnt_reg;
        ms_next        = ms_reg;
        crc_next       = crc_reg;
        k_next         = k_reg;
        ch_next        = ch_reg;
        h0_next        = h0_reg;
        h1_next        = h1_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rec_next   = out_rec_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_off         = k_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_item.is_tick && slot_free)
                begin
                    q_pop                          = 1'b1;
                    ms_next                        = ms_inc;
                    out_valid_next                 = 1'b1;
                    out_rec_next.kind              = sumd_pkg::KIND_STATUS;
                    out_rec_next.channel_index     = 5'd0;
                    out_rec_next.channel_value     = 13'd0;
                    out_rec_next.channels_received = last_cnt_reg;
                    out_rec_next.failsafe_active   = fs_reg || (ms_inc > timeout_reg);
                    out_rec_next.last              = 1'b1;
                end
                else if (q_valid && !q_item.is_tick)
                begin
                    q_pop   = 1'b1;
                    wr_en   = 1'b1;
                    wp_next = wp_inc;
                    if (wp_inc == rp_reg)
                        rp_next = ring_add(rp_reg, 7'd1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                k_next   = 7'd0;
                crc_next = 16'h0000;
                if (hdr_seen_reg)
                    state_next = (held >= (PW + 1)'(flen)) ? S_CRC_A : S_IDLE;
                else
                    state_next = (held >= (PW + 1)'(sumd_pkg::HDR_LEN)) ? S_HDR_A : S_IDLE;
            end
            S_HDR_A:
            begin
                rd_en      = 1'b1;
                rd_off     = k_reg;
                state_next = S_HDR_D;
            end
            S_HDR_D:
            begin
                k_next     = k_reg + 7'd1;
                state_next = S_HDR_A;
                if (k_reg == 7'd0)
                    h0_next = rd_data_reg;
                else if (k_reg == 7'd1)
                    h1_next = rd_data_reg;
                else
                begin
                    state_next = S_SCAN;
                    if (hdr_ok)
                    begin
                        hdr_seen_next = 1'b1;
                        fs_next       = (h1_reg == sumd_pkg::HDR_FAILSAFE);
                        cnt_next      = rd_data_reg[5:0];
                    end
                    else
                        rp_next = ring_add(rp_reg, 7'd1);
                end
            end
            S_CRC_A:
            begin
                rd_en      = 1'b1;
                rd_off     = k_reg;
                state_next = S_CRC_D;
            end
            S_CRC_D:
            begin
                crc_next   = sumd_pkg::crc_byte(crc_reg, rd_data_reg);
                k_next     = k_reg + 7'd1;
                state_next = (k_reg + 7'd1 == flen) ? S_CRC_END : S_CRC_A;
            end
            S_CRC_END:
            begin
                hdr_seen_next = 1'b0;
                ch_next       = 5'd0;
                if (crc_reg != 16'h0000)
                begin
                    rp_next    = ring_add(rp_reg, 7'd1);
                    state_next = S_IDLE;
                end
                else
                begin
                    last_cnt_next = cnt_reg;
                    ms_next       = 16'd0;
                    state_next    = S_HI_A;
                end
            end
            S_HI_A:
            begin
                rd_en      = 1'b1;
                rd_off     = {1'b0, ch_reg, 1'b0} + sumd_pkg::HDR_LEN;
                state_next = S_HI_D;
            end
            S_HI_D:
            begin
                h0_next    = rd_data_reg;
                state_next = S_LO_A;
            end
            S_LO_A:
            begin
                rd_en      = 1'b1;
                rd_off     = {1'b0, ch_reg, 1'b0} + sumd_pkg::HDR_LEN + 7'd1;
                state_next = S_LO_D;
            end
            S_LO_D:
            begin
                // Hold the fetched byte until the output register is free.
                if (slot_free)
                begin
                    out_valid_next                 = 1'b1;
                    out_rec_next.kind              = sumd_pkg::KIND_CHAN;
                    out_rec_next.channel_index     = ch_reg;
                    out_rec_next.channel_value     = ch_value;
                    out_rec_next.channels_received = last_cnt_reg;
                    out_rec_next.failsafe_active   = fs_reg;
                    out_rec_next.last              = ({1'b0, ch_reg} + 6'd1 == cnt_reg);
                    if ({1'b0, ch_reg} + 6'd1 == cnt_reg)
                    begin
                        rp_next    = ring_add(rp_reg, flen);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 5'd1;
                        state_next = S_HI_A;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = ring_add(rp_reg, rd_off);

    // Control and status registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            hdr_seen_reg  <= 1'b0;
            cnt_reg       <= 6'd0;
            fs_reg        <= 1'b1;
            last_cnt_reg  <= 6'd0;
            ms_reg        <= 16'd0;
            timeout_reg   <= sumd_pkg::TIMEOUT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            hdr_seen_reg  <= hdr_seen_next;
            cnt_reg       <= cnt_next;
            fs_reg        <= fs_next;
            last_cnt_reg  <= last_cnt_next;
            ms_reg        <= ms_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                timeout_reg <= cfg_wdata;
        end
    end

    // Working registers that carry payload only.
    always_ff @(posedge clk)
    begin
        crc_reg     <= crc_next;
        k_reg       <= k_next;
        ch_reg      <= ch_next;
        h0_reg      <= h0_next;
        h1_reg      <= h1_next;
        out_rec_reg <= out_rec_next;
    end

    // Byte ring with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring[wp_reg] <= q_item.data;
        if (rd_en)
            rd_data_reg <= ring[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("queue popped while an item is in progress");
    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_seen_reg |-> (cnt_reg >= 6'd2 && 8'(cnt_reg) <= MAX_CH))
        else $error("held header has an illegal channel count");
    a_crc_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRC_A || state_reg == S_CRC_D) |-> hdr_seen_reg)
        else $error("CRC walk without a held header");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_rec_reg))
        else $error("pending record overwritten");
`endif

endmodule

FILE: dv/tb.sv
// Self-checking testbench for sumd_frame_decoder: random byte streams and ticks
// are checked against an in-bench model of the ring, the header search and the CRC.
// Depends on sumd_pkg and the sumd_frame_decoder RTL.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 128;
    localparam int MAXCH      = 32;
    localparam int DRAIN_WAIT = 2000;
    localparam int LONG_HOLD  = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = sumd_pkg::MODE_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [4:0]  channel_index;
    logic [12:0] channel_value;
    logic [5:0]  channels_received;
    logic        failsafe_active;
    logic        last;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    sumd_frame_decoder uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
        .channel_index(channel_index), .channel_value(channel_value),
        .channels_received(channels_received), .failsafe_active(failsafe_active),
        .last(last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    // Items waiting to be offered and records still owed by the block.
    sumd_pkg::item_t   pending_items[$];
    sumd_pkg::record_t owed_records[$];
    int                mismatches = 0;
    logic              in_fire = 1'b0;

    // Sender and receiver behaviour controls.
    bit      sender_gaps = 1'b1;
    bit      recv_stalls = 1'b1;
    int      hold_requests = 0;

    // Decoder model state.
    logic [7:0]  m_ring [0:DEPTH-1];
    logic [6:0]  m_rd, m_wr;
    bit          m_hdr;
    logic [5:0]  m_count;
    bit          m_failsafe;
    logic [5:0]  m_last_count;
    logic [15:0] m_ms;
    logic [15:0] m_timeout;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] r;
        bit          fb;
        r = c;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ v[i];
            r = {r[14:0], 1'b0};
            if (fb)
                r = r ^ sumd_pkg::CRC_POLY;
        end
        return r;
    endfunction

    function automatic logic [6:0] held_count();
        return m_wr - m_rd;
    endfunction

    function automatic logic [7:0] ring_byte(input int off);
        logic [6:0] p;
        p = m_rd + off[6:0];
        return m_ring[p];
    endfunction

    // Works out the records that one accepted item causes.
    task automatic decode_item(input logic m, input logic [7:0] b);
        sumd_pkg::record_t rec;
        logic [15:0]       crc;
        int                flen;
        logic [7:0]        hi, lo;
        if (m == sumd_pkg::MODE_TICK)
        begin
            if (m_ms != sumd_pkg::MS_MAX)
                m_ms = m_ms + 16'd1;
            rec = '0;
            rec.kind = sumd_pkg::KIND_STATUS;
            rec.channels_received = m_last_count;
            rec.failsafe_active = m_failsafe || (m_ms > m_timeout);
            rec.last = 1'b1;
            owed_records.push_back(rec);
            return;
        end
        m_ring[m_wr] = b;
        m_wr = m_wr + 7'd1;
        if (m_wr == m_rd)
            m_rd = m_rd + 7'd1;
        while (!m_hdr && held_count() >= sumd_pkg::HDR_LEN)
        begin
            if (ring_byte(0) == sumd_pkg::HDR_START &&
                (ring_byte(1) == sumd_pkg::HDR_OK || ring_byte(1) == sumd_pkg::HDR_FAILSAFE) &&
                ring_byte(2) >= sumd_pkg::MIN_CHANNELS && ring_byte(2) <= MAXCH)
            begin
                m_hdr = 1'b1;
                m_failsafe = (ring_byte(1) == sumd_pkg::HDR_FAILSAFE);
                m_count = 6'(ring_byte(2));
            end
            else
                m_rd = m_rd + 7'd1;
        end
        if (!m_hdr)
            return;
        flen = sumd_pkg::HDR_LEN + 2 * m_count + sumd_pkg::CRC_LEN;
        if (held_count() < flen)
            return;
        crc = 16'h0000;
        for (int k = 0; k < flen; k++)
            crc = crc_step(crc, ring_byte(k));
        m_hdr = 1'b0;
        if (crc != 16'h0000)
        begin
            m_rd = m_rd + 7'd1;
            return;
        end
        m_last_count = m_count;
        m_ms = 16'h0000;
        for (int k = 0; k < m_count; k++)
        begin
            hi = ring_byte(sumd_pkg::HDR_LEN + 2 * k);
            lo = ring_byte(sumd_pkg::HDR_LEN + 2 * k + 1);
            rec.kind = sumd_pkg::KIND_CHAN;
            rec.channel_index = k[4:0];
            rec.channel_value = {hi, 5'b00000} + {5'b00000, lo[7:3]};
            rec.channels_received = m_last_count;
            rec.failsafe_active = m_failsafe;
            rec.last = (k + 1 == m_count);
            owed_records.push_back(rec);
        end
        m_rd = m_rd + flen[6:0];
    endtask

    // Input acceptance, configuration tracking and output checking at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
            m_rd = '0; m_wr = '0; m_hdr = 1'b0; m_count = '0; m_failsafe = 1'b1;
            m_last_count = '0; m_ms = '0; m_timeout = sumd_pkg::TIMEOUT_RST;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (cfg_we)
                m_timeout = cfg_wdata;
            if (in_valid && in_ready)
                decode_item(mode, rx_byte);
            if (out_valid && out_ready)
            begin
                if (owed_records.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected record kind=%0d idx=%0d val=%0d",
                                 kind, channel_index, channel_value);
                end
                else if ({kind, channel_index, channel_value, channels_received,
                          failsafe_active, last} != owed_records[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected %p, got kind=%0d idx=%0d val=%0d",
                                  " cnt=%0d fs=%0d last=%0d"},
                                 owed_records[0], kind, channel_index, channel_value,
                                 channels_received, failsafe_active, last);
                    void'(owed_records.pop_front());
                end
                else
                    void'(owed_records.pop_front());
            end
        end
    end

    // Sender: offers queued items in bursts separated by random gaps.
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge clk)
    begin
        sumd_pkg::item_t it;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                mode <= it.is_tick;
                rx_byte <= it.data;
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= sender_gaps ? $urandom_range(0, 8) : 0;
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall pattern plus an occasional long hold-off.
    int hold_left = 0;
    int holds_done = 0;
    always @(negedge clk)
    begin
        if (hold_requests != holds_done)
        begin
            holds_done <= hold_requests;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= recv_stalls ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    task automatic put_byte(input logic [7:0] v);
        pending_items.push_back('{is_tick: sumd_pkg::MODE_BYTE, data: v});
    endtask

    task automatic put_tick();
        pending_items.push_back('{is_tick: sumd_pkg::MODE_TICK, data: 8'($urandom)});
    endtask

    // Queues one frame; a corrupt frame has one bit of its CRC flipped.
    task automatic put_frame(input int n, input bit fs, input bit corrupt, input bit extreme);
        logic [7:0]  fb [$];
        logic [15:0] c;
        fb.push_back(sumd_pkg::HDR_START);
        fb.push_back(fs ? sumd_pkg::HDR_FAILSAFE : sumd_pkg::HDR_OK);
        fb.push_back(8'(n));
        for (int k = 0; k < 2 * n; k++)
            fb.push_back(extreme ? ((k % 4 < 2) ? 8'hFF : 8'h00) : 8'($urandom));
        c = 16'h0000;
        foreach (fb[i])
            c = crc_step(c, fb[i]);
        if (corrupt)
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        fb.push_back(c[15:8]);
        fb.push_back(c[7:0]);
        foreach (fb[i])
            put_byte(fb[i]);
    endtask

    // Queues a random mix of about n items, mostly well-formed frames.
    task automatic put_mix(input int n);
        int added;
        int r;
        int ch;
        added = 0;
        while (added < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                ch = ($urandom_range(0, 19) == 0) ? MAXCH : $urandom_range(2, 6);
                put_frame(ch, $urandom_range(0, 1), 1'b0, 1'b0);
                added += 2 * ch + 5;
            end
            else if (r < 70)
            begin
                put_frame($urandom_range(2, 5), $urandom_range(0, 1), 1'b1, 1'b0);
                added += 10;
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    put_byte(8'($urandom));
                    added++;
                end
            end
            else if (r < 90)
            begin
                // Broken header: bad second byte or a channel count out of range.
                put_byte(sumd_pkg::HDR_START);
                if ($urandom_range(0, 1))
                begin
                    put_byte(8'($urandom));
                    put_byte(8'($urandom_range(2, 6)));
                end
                else
                begin
                    put_byte(sumd_pkg::HDR_OK);
                    put_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                                  : 8'($urandom_range(MAXCH + 1, 255)));
                end
                added += 3;
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    put_tick();
                    added++;
                end
            end
        end
    endtask

    // Waits until every queued item is taken and every owed record has come.
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || owed_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: byte extremes, ticks, good and bad two-channel frames.
        put_tick();
        put_byte(8'h00);
        put_byte(8'hFF);
        pending_items.push_back('{is_tick: sumd_pkg::MODE_TICK, data: 8'hFF});
        pending_items.push_back('{is_tick: sumd_pkg::MODE_TICK, data: 8'h00});
        put_frame(2, 1'b0, 1'b0, 1'b1);
        put_frame(2, 1'b1, 1'b1, 1'b0);
        put_tick();
        wait_idle();

        // Timeout of one: a couple of ticks already time out.
        write_timeout(16'd1);
        put_tick(); put_tick(); put_tick();
        put_mix(20);
        wait_idle();

        // Zero timeout, with a long receiver hold-off while frames keep coming.
        write_timeout(16'd0);
        put_tick();
        put_frame(MAXCH, 1'b0, 1'b0, 1'b1);
        put_mix(10);
        hold_requests++;
        wait_idle();

        // Random timeout, no idling on either side.
        write_timeout(16'($urandom_range(1, 20)));
        sender_gaps = 1'b0;
        recv_stalls = 1'b0;
        put_mix(15);
        repeat (10) put_tick();
        wait_idle();

        // Largest timeout.
        sender_gaps = 1'b1;
        recv_stalls = 1'b1;
        write_timeout(16'hFFFF);
        put_mix(10);
        wait_idle();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Left-over records at the end are caught by wait_idle never returning.
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
